// ===== design/i2c_tap_pkg.sv =====
// Shared types and constants for the im2col tap address generator.
// No dependencies; imported by every module of the block but the checker.
`timescale 1ns / 1ps
package i2c_tap_pkg;

  localparam int MAX_KERNEL    = 8;
  localparam int MAX_IMAGE_DIM = 4096;

  localparam int ROW_W    = 12;                     // out_row / out_col
  localparam int DIM_W    = 13;                     // image height / width
  localparam int KDIM_W   = 4;                      // kernel size register
  localparam int STEP_W   = 4;                      // stride register
  localparam int PAD_W    = 3;                      // padding register
  localparam int TAP_W    = $clog2(MAX_KERNEL);     // tap row / col
  localparam int PROD_W   = ROW_W + STEP_W;         // out_row * step
  localparam int COORD_W  = PROD_W + 1;             // signed window origin
  localparam int INDEX_W  = 24;                     // pixel_index
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 13;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_HEIGHT  = 3'd0,
    REG_IMAGE_WIDTH   = 3'd1,
    REG_KERNEL_HEIGHT = 3'd2,
    REG_KERNEL_WIDTH  = 3'd3,
    REG_ROW_STEP      = 3'd4,
    REG_COL_STEP      = 3'd5,
    REG_PAD_TOP       = 3'd6,
    REG_PAD_LEFT      = 3'd7
  } cfg_reg_e;

  // Configuration after saturation, as the datapath uses it.
  typedef struct packed {
    logic [DIM_W-1:0]  img_h;
    logic [DIM_W-1:0]  img_w;
    logic [TAP_W-1:0]  kh_m1;
    logic [TAP_W-1:0]  kw_m1;
    logic [STEP_W-1:0] row_step;
    logic [STEP_W-1:0] col_step;
    logic [PAD_W-1:0]  pad_top;
    logic [PAD_W-1:0]  pad_left;
  } i2c_cfg_t;

  // Window origin of one output pixel, may be negative.
  typedef struct packed {
    logic signed [COORD_W-1:0] base_y;
    logic signed [COORD_W-1:0] base_x;
  } win_origin_t;

endpackage

// ===== design/i2c_tap_front.sv =====
// Front end: accepts output pixel positions and computes the window origin.
// Depends on i2c_tap_pkg.
`timescale 1ns / 1ps
module i2c_tap_front
  import i2c_tap_pkg::*;
(
  input  i2c_cfg_t           cfg,
  input  logic [ROW_W-1:0]   out_row,
  input  logic [ROW_W-1:0]   out_col,
  output win_origin_t        origin
);

  logic [PROD_W-1:0] prod_y;
  logic [PROD_W-1:0] prod_x;

  assign prod_y = PROD_W'(out_row) * PROD_W'(cfg.row_step);
  assign prod_x = PROD_W'(out_col) * PROD_W'(cfg.col_step);

  assign origin.base_y = $signed({1'b0, prod_y}) -
                         $signed({{(COORD_W-PAD_W){1'b0}}, cfg.pad_top});
  assign origin.base_x = $signed({1'b0, prod_x}) -
                         $signed({{(COORD_W-PAD_W){1'b0}}, cfg.pad_left});

endmodule

// ===== design/i2c_tap_queue.sv =====
// Short FIFO of window origins between the front end and the tap walker.
// Depends on i2c_tap_pkg.
`timescale 1ns / 1ps
module i2c_tap_queue
  import i2c_tap_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  win_origin_t push_data,
  output logic        full,
  input  logic        pop,
  output logic        valid,
  output win_origin_t pop_data
);

  win_origin_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]    rptr_r, rptr_nxt;
  logic [QPTR_W:0]      count_r, count_nxt;

  assign full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

// ===== design/i2c_tap_back.sv =====
// Tap walker: walks the filter window row-major, one tap per cycle unless
// stalled; bounds-checks each tap, forms its flat pixel index. Uses i2c_tap_pkg.
`timescale 1ns / 1ps
module i2c_tap_back
  import i2c_tap_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  i2c_cfg_t           cfg,
  input  logic               q_valid,
  input  win_origin_t        q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TAP_W-1:0]   tap_row,
  output logic [TAP_W-1:0]   tap_col,
  output logic               inside_res,
  output logic [INDEX_W-1:0] pixel_index,
  output logic               last_tap
);

  localparam int MUL_W = 2 * DIM_W;

  logic                      cur_valid_r, cur_valid_nxt;
  win_origin_t               cur_r, cur_nxt;
  logic [TAP_W-1:0]          ty_r, ty_nxt;
  logic [TAP_W-1:0]          tx_r, tx_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [TAP_W-1:0]          tap_row_r, tap_col_r;
  logic                      inside_r, last_r;
  logic [INDEX_W-1:0]        index_r;

  logic                      out_free, step, tap_end, row_end;
  logic signed [COORD_W-1:0] y, x;
  logic                      in_image;
  logic [MUL_W-1:0]          idx_sum;
  logic [INDEX_W-1:0]        idx;

  assign out_free = !out_valid_r || out_ready;
  assign step     = cur_valid_r && out_free;
  assign row_end  = (tx_r == cfg.kw_m1);
  assign tap_end  = row_end && (ty_r == cfg.kh_m1);
  assign q_pop    = q_valid && (!cur_valid_r || (step && tap_end));

  // Tap position and bounds check
  assign y = cur_r.base_y + $signed({{(COORD_W-TAP_W){1'b0}}, ty_r});
  assign x = cur_r.base_x + $signed({{(COORD_W-TAP_W){1'b0}}, tx_r});
  assign in_image = !y[COORD_W-1] && (y[COORD_W-2:0] < (COORD_W-1)'(cfg.img_h)) &&
                    !x[COORD_W-1] && (x[COORD_W-2:0] < (COORD_W-1)'(cfg.img_w));

  // Inside taps have y and x below MAX_IMAGE_DIM, so DIM_W bits suffice.
  assign idx_sum = MUL_W'(y[DIM_W-1:0]) * MUL_W'(cfg.img_w) + MUL_W'(x[DIM_W-1:0]);
  assign idx     = in_image ? idx_sum[INDEX_W-1:0] : '0;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    ty_nxt        = ty_r;
    tx_nxt        = tx_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      cur_nxt       = q_data;
      ty_nxt        = '0;
      tx_nxt        = '0;
    end else if (step && tap_end) begin
      cur_valid_nxt = 1'b0;
    end else if (step) begin
      if (row_end) begin
        tx_nxt = '0;
        ty_nxt = ty_r + 1'b1;
      end else begin
        tx_nxt = tx_r + 1'b1;
      end
    end

    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    ty_r  <= ty_nxt;
    tx_r  <= tx_nxt;
    if (step) begin
      tap_row_r <= ty_r;
      tap_col_r <= tx_r;
      inside_r  <= in_image;
      index_r   <= idx;
      last_r    <= tap_end;
    end
  end

  assign out_valid   = out_valid_r;
  assign tap_row     = tap_row_r;
  assign tap_col     = tap_col_r;
  assign inside_res  = inside_r;
  assign pixel_index = index_r;
  assign last_tap    = last_r;

endmodule

// ===== design/im2col_tap_address_generator_top.sv =====
// Top level of the im2col tap address generator: configuration registers,
// front end, origin queue and tap walker. Depends on i2c_tap_pkg and submodules.
`timescale 1ns / 1ps
// Usage
//  - Input stream (in_*): one transfer per output pixel, in_tdata carries
//    out_row and out_col. Each transfer produces kernel_height * kernel_width
//    result transfers on the output stream, row-major over the filter window.
//  - Output stream (out_*): out_tdata carries tap_row, tap_col and the flat
//    pixel index (row * image_width + column, zero for padding taps);
//    out_tuser is high when the tap lies inside the image; out_tlast marks
//    the final tap of the window.
//  - Config port: write cfg_wdata into register cfg_addr whenever cfg_we is
//    high. Only write while the block is idle. Kernel sizes saturate to
//    1..8, image sizes to 4096.
//  - Flow: the first tap of an item passes through the origin queue, the
//    walker's window register and the output register. The tap walker emits
//    one tap per cycle while out_tready does not stall it; consecutive items
//    run with no bubble between them.
//  - Back-pressure: a two-entry origin queue decouples input and walker;
//    when out_tready is low the current tap holds in the output register
//    and in_tready drops once the queue is full.
//  - Reset (rst_n low, synchronous) empties the queue and the walker and
//    restores the defaults: 1x1 image and kernel, unit stride, no padding.
module im2col_tap_address_generator_top
  import i2c_tap_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // [11:0] out_row, [23:12] out_col

  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [2:0] tap_row, [5:3] tap_col,
                                            // [29:6] pixel_index, [31:30] zero
  output logic                  out_tuser,  // [0] inside_res
  output logic                  out_tlast,  // last_tap

  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Raw register values, as written
  logic [DIM_W-1:0]  img_h_r, img_w_r;
  logic [KDIM_W-1:0] ker_h_r, ker_w_r;
  logic [STEP_W-1:0] row_step_r, col_step_r;
  logic [PAD_W-1:0]  pad_top_r, pad_left_r;

  i2c_cfg_t    cfg;
  win_origin_t front_origin;
  win_origin_t q_data;
  logic        q_full, q_valid, q_pop, in_xfer;

  logic [TAP_W-1:0]   tap_row, tap_col;
  logic [INDEX_W-1:0] pixel_index;
  logic               inside_res, last_tap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_h_r    <= DIM_W'(1);
      img_w_r    <= DIM_W'(1);
      ker_h_r    <= KDIM_W'(1);
      ker_w_r    <= KDIM_W'(1);
      row_step_r <= STEP_W'(1);
      col_step_r <= STEP_W'(1);
      pad_top_r  <= '0;
      pad_left_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_addr))
        REG_IMAGE_HEIGHT:  img_h_r    <= cfg_wdata[DIM_W-1:0];
        REG_IMAGE_WIDTH:   img_w_r    <= cfg_wdata[DIM_W-1:0];
        REG_KERNEL_HEIGHT: ker_h_r    <= cfg_wdata[KDIM_W-1:0];
        REG_KERNEL_WIDTH:  ker_w_r    <= cfg_wdata[KDIM_W-1:0];
        REG_ROW_STEP:      row_step_r <= cfg_wdata[STEP_W-1:0];
        REG_COL_STEP:      col_step_r <= cfg_wdata[STEP_W-1:0];
        REG_PAD_TOP:       pad_top_r  <= cfg_wdata[PAD_W-1:0];
        REG_PAD_LEFT:      pad_left_r <= cfg_wdata[PAD_W-1:0];
      endcase
    end
  end

  // Saturation: kernel 0 acts as 1, above 8 as 8; image above 4096 as 4096.
  always_comb begin
    cfg.img_h = (img_h_r > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : img_h_r;
    cfg.img_w = (img_w_r > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : img_w_r;
    priority if (ker_h_r == '0)                      cfg.kh_m1 = '0;
    else if (ker_h_r > KDIM_W'(MAX_KERNEL))          cfg.kh_m1 = TAP_W'(MAX_KERNEL-1);
    else                                             cfg.kh_m1 = TAP_W'(ker_h_r - 1'b1);
    priority if (ker_w_r == '0)                      cfg.kw_m1 = '0;
    else if (ker_w_r > KDIM_W'(MAX_KERNEL))          cfg.kw_m1 = TAP_W'(MAX_KERNEL-1);
    else                                             cfg.kw_m1 = TAP_W'(ker_w_r - 1'b1);
    cfg.row_step = row_step_r;
    cfg.col_step = col_step_r;
    cfg.pad_top  = pad_top_r;
    cfg.pad_left = pad_left_r;
  end

  assign in_tready = !q_full;
  assign in_xfer   = in_tvalid && in_tready;

  i2c_tap_front u_front (
    .cfg     (cfg),
    .out_row (in_tdata[ROW_W-1:0]),
    .out_col (in_tdata[2*ROW_W-1:ROW_W]),
    .origin  (front_origin)
  );

  i2c_tap_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_data (front_origin),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  i2c_tap_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .tap_row     (tap_row),
    .tap_col     (tap_col),
    .inside_res  (inside_res),
    .pixel_index (pixel_index),
    .last_tap    (last_tap)
  );

  assign out_tdata = {2'b00, pixel_index, tap_col, tap_row};
  assign out_tuser = inside_res;
  assign out_tlast = last_tap;

endmodule

// ===== design/i2c_tap_checker.sv =====
// Port-level checks for the im2col tap address generator, bound to the top.
// Depends on im2col_tap_address_generator_top.
`timescale 1ns / 1ps
module i2c_tap_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // Nothing is presented right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // The origin queue is empty after reset, so input is open.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // Padding taps carry a zero pixel index.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[29:6] == 24'd0)
    else $error("padding tap with nonzero pixel index");

  // A stalled tap holds all of its fields.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output changed");

endmodule

bind im2col_tap_address_generator_top i2c_tap_checker u_i2c_tap_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
